// ===== hdl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

   localparam int unsigned REQ_W     = 2;
   localparam int unsigned ADDR_IN_W = 52;
   localparam int unsigned ADDR_W    = 28;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_MODIFY,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      WOP_SET,
      WOP_CLEAR,
      WOP_CLAIM
   } word_op_type;

endpackage

`default_nettype wire

// ===== hdl/bfa_bitmap_mem.sv =====
// Single-port bitmap word store with registered read data.
`default_nettype none

module bfa_bitmap_mem #(
   parameter int unsigned DATA_W = 64,
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic              wr_en,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bfa_word_unit.sv =====
// Shared word unit: range mask, set/clear of a bit range, first-clear-bit claim.
`default_nettype none

module bfa_word_unit #(
   parameter int unsigned LOG_W = 6
) (
   input  wire bfa_pkg::word_op_type     op,
   input  wire logic [LOG_W-1:0]         lo,
   input  wire logic [LOG_W:0]           hi,
   input  wire logic [(1<<LOG_W)-1:0]    rd_data,
   output logic      [(1<<LOG_W)-1:0]    wr_data,
   output logic                          hit,
   output logic      [LOG_W-1:0]         hit_bit
);

   localparam int unsigned MEM_W = 1 << LOG_W;

   logic [MEM_W-1:0] ones;
   logic [MEM_W-1:0] range_mask;
   logic [MEM_W-1:0] cand;
   logic [MEM_W-1:0] claim_bit;

   assign ones       = {MEM_W{1'b1}};
   // bits lo .. hi-1; hi == MEM_W shifts everything out, giving all ones
   assign range_mask = (ones << lo) & ~(ones << hi);
   assign cand       = ~rd_data & range_mask;

   always_comb begin
      hit     = 1'b0;
      hit_bit = '0;
      for (int i = MEM_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit     = 1'b1;
            hit_bit = LOG_W'(i);
         end
      end
   end

   assign claim_bit = hit ? (MEM_W'(1) << hit_bit) : '0;

   always_comb begin
      unique case (op)
         bfa_pkg::WOP_SET:   wr_data = rd_data | range_mask;
         bfa_pkg::WOP_CLEAR: wr_data = rd_data & ~range_mask;
         bfa_pkg::WOP_CLAIM: wr_data = rd_data | claim_bit;
         default:            wr_data = rd_data;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/bitmap_frame_allocator.sv =====
// Top level: first-fit bitmap page frame allocator with word-serial sequencer.
// Reset runs a fill pass, all-ones into each bitmap word, one per cycle (NUM_WORDS, 1024 by
// default), with no request taken. Each bitmap word visited takes a read state and a write state.
// Words visited per request: alloc, up to the mark or the first hit; range, words touched;
// free, one, none past the bitmap; empty range, none. The result register frees the input
// side while a result waits.
`default_nettype none

module bitmap_frame_allocator #(
   parameter int unsigned NUM_FRAMES  = 65536,
   parameter int unsigned FRAME_SHIFT = 12,
   parameter int unsigned WORD_BITS   = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [51:0] start_addr, [103:52] end_addr
   input  wire logic [bfa_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [1:0] req_type
   input  wire logic [bfa_pkg::REQ_W-1:0]            req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [27:0] frame_addr, [31:28] zero
   output logic      [bfa_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] found
   output logic                                      rsp_tuser
);

   localparam int unsigned LOG_W     = $clog2(WORD_BITS);
   localparam int unsigned MEM_W     = 1 << LOG_W;
   localparam int unsigned NUM_WORDS = (NUM_FRAMES + MEM_W - 1) / MEM_W;
   localparam int unsigned WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned FIW       = $clog2(NUM_FRAMES);
   localparam int unsigned FW        = $clog2(NUM_FRAMES + 1);
   localparam int unsigned SW        = bfa_pkg::ADDR_IN_W + 1;
   localparam int unsigned AW0       = WAW + LOG_W + FRAME_SHIFT;
   localparam int unsigned PW        = (AW0 > bfa_pkg::ADDR_W) ? AW0 : bfa_pkg::ADDR_W;

   bfa_pkg::state_type    state_ff, state_in;
   bfa_pkg::word_op_type  op_ff, op_in;
   logic [bfa_pkg::REQ_W-1:0]     req_type_ff, req_type_in;
   logic [bfa_pkg::ADDR_IN_W-1:0] start_ff, start_in;
   logic [bfa_pkg::ADDR_IN_W-1:0] end_ff, end_in;
   logic [FIW-1:0]                mark_ff, mark_in;
   logic [FIW-1:0]                end_frame_ff, end_frame_in;
   logic [WAW-1:0]                word_ff, word_in;
   logic [LOG_W-1:0]              lo_ff, lo_in;
   logic [bfa_pkg::ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                          res_found_ff, res_found_in;
   logic [bfa_pkg::ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [bfa_pkg::ADDR_IN_W-1:0] first_full;
   logic [SW-1:0]                 round_sum;
   logic [SW-1:0]                 last_full;
   logic [FW-1:0]                 last_c;
   logic [FIW-1:0]                last_m1;
   logic [FIW-1:0]                first_idx;
   logic                          range_ok;
   logic                          free_ok;

   logic [WAW-1:0]     end_word;
   logic               at_end;
   logic [LOG_W:0]     hi_sel;
   logic [MEM_W-1:0]   rd_data;
   logic [MEM_W-1:0]   unit_data;
   logic               unit_hit;
   logic [LOG_W-1:0]   unit_bit;
   logic               mem_we;
   logic [MEM_W-1:0]   mem_wdata;
   logic [PW-1:0]      addr_wide;

   logic req_xfer;
   logic rsp_xfer;
   logic rsp_load;

   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_valid_ff & rsp_tready;
   assign rsp_load = (state_ff == bfa_pkg::ST_RESP) & (~rsp_valid_ff | rsp_tready);

   // request decode, from the latched transfer
   assign first_full = start_ff >> FRAME_SHIFT;
   assign round_sum  = {1'b0, end_ff} + (SW'(1) << FRAME_SHIFT) - SW'(1);
   assign last_full  = (req_type_ff == bfa_pkg::REQ_RESERVE) ? (round_sum >> FRAME_SHIFT)
                                                             : ({1'b0, end_ff} >> FRAME_SHIFT);
   assign last_c     = (last_full > SW'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : last_full[FW-1:0];
   assign range_ok   = {1'b0, first_full} < SW'(last_c);
   assign free_ok    = first_full < bfa_pkg::ADDR_IN_W'(NUM_FRAMES);
   assign last_m1    = FIW'(last_c - FW'(1));
   assign first_idx  = first_full[FIW-1:0];

   // word walk
   assign end_word  = WAW'(end_frame_ff >> LOG_W);
   assign at_end    = word_ff == end_word;
   assign hi_sel    = at_end ? ({1'b0, end_frame_ff[LOG_W-1:0]} + (LOG_W+1)'(1))
                             : (LOG_W+1)'(MEM_W);
   assign addr_wide = PW'({word_ff, unit_bit}) << FRAME_SHIFT;

   bfa_bitmap_mem #(
      .DATA_W (MEM_W),
      .DEPTH  (NUM_WORDS),
      .ADDR_W (WAW)
   ) u_mem (
      .clock   (clock),
      .addr    (word_ff),
      .wr_en   (mem_we),
      .wr_data (mem_wdata),
      .rd_data (rd_data)
   );

   bfa_word_unit #(
      .LOG_W (LOG_W)
   ) u_unit (
      .op      (op_ff),
      .lo      (lo_ff),
      .hi      (hi_sel),
      .rd_data (rd_data),
      .wr_data (unit_data),
      .hit     (unit_hit),
      .hit_bit (unit_bit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfa_pkg::ST_CLEAR: begin
            if (word_ff == WAW'(NUM_WORDS - 1)) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         bfa_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = bfa_pkg::ST_DECODE;
            end
         end
         bfa_pkg::ST_DECODE: begin
            unique case (req_type_ff)
               bfa_pkg::REQ_ALLOC: state_in = bfa_pkg::ST_READ;
               bfa_pkg::REQ_FREE:  state_in = free_ok ? bfa_pkg::ST_READ : bfa_pkg::ST_RESP;
               default:            state_in = range_ok ? bfa_pkg::ST_READ : bfa_pkg::ST_RESP;
            endcase
         end
         bfa_pkg::ST_READ: begin
            state_in = bfa_pkg::ST_MODIFY;
         end
         bfa_pkg::ST_MODIFY: begin
            if (((op_ff == bfa_pkg::WOP_CLAIM) & unit_hit) | at_end) begin
               state_in = bfa_pkg::ST_RESP;
            end else begin
               state_in = bfa_pkg::ST_READ;
            end
         end
         bfa_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: state_in = bfa_pkg::ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_type_in  = req_type_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      mark_in      = mark_ff;
      end_frame_in = end_frame_ff;
      word_in      = word_ff;
      lo_in        = lo_ff;
      op_in        = op_ff;
      res_addr_in  = res_addr_ff;
      res_found_in = res_found_ff;
      mem_we       = 1'b0;
      mem_wdata    = unit_data;
      req_tready   = 1'b0;

      unique case (state_ff)
         bfa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {MEM_W{1'b1}};
            word_in   = word_ff + WAW'(1);
         end
         bfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               req_type_in = req_tuser;
               start_in    = req_tdata[bfa_pkg::ADDR_IN_W-1:0];
               end_in      = req_tdata[2*bfa_pkg::ADDR_IN_W-1:bfa_pkg::ADDR_IN_W];
            end
         end
         bfa_pkg::ST_DECODE: begin
            res_addr_in  = '0;
            res_found_in = 1'b0;
            unique case (req_type_ff)
               bfa_pkg::REQ_ALLOC: begin
                  op_in        = bfa_pkg::WOP_CLAIM;
                  word_in      = '0;
                  lo_in        = '0;
                  end_frame_in = mark_ff;
               end
               bfa_pkg::REQ_FREE: begin
                  op_in        = bfa_pkg::WOP_CLEAR;
                  word_in      = WAW'(first_idx >> LOG_W);
                  lo_in        = first_idx[LOG_W-1:0];
                  end_frame_in = first_idx;
               end
               default: begin
                  op_in        = (req_type_ff == bfa_pkg::REQ_RESERVE) ? bfa_pkg::WOP_SET
                                                                       : bfa_pkg::WOP_CLEAR;
                  word_in      = WAW'(first_idx >> LOG_W);
                  lo_in        = first_idx[LOG_W-1:0];
                  end_frame_in = last_m1;
                  if ((req_type_ff == bfa_pkg::REQ_RELEASE) & range_ok & (last_m1 > mark_ff)) begin
                     mark_in = last_m1;
                  end
               end
            endcase
         end
         bfa_pkg::ST_READ: begin
         end
         bfa_pkg::ST_MODIFY: begin
            mem_we  = 1'b1;
            lo_in   = '0;
            word_in = word_ff + WAW'(1);
            if ((op_ff == bfa_pkg::WOP_CLAIM) & unit_hit) begin
               res_addr_in  = addr_wide[bfa_pkg::ADDR_W-1:0];
               res_found_in = 1'b1;
            end
         end
         bfa_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_found_in = rsp_found_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_found_in = res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::ST_CLEAR;
         word_ff      <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      end_frame_ff <= end_frame_in;
      lo_ff        <= lo_in;
      op_ff        <= op_in;
      res_addr_ff  <= res_addr_in;
      res_found_ff <= res_found_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bfa_pkg::RSP_DATA_W'(rsp_addr_ff);
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire

// ===== bench/bitmap_frame_allocator_checker.sv =====
// Checker for the bitmap frame allocator: tracks the frame bitmap and compares each response.
module bitmap_frame_allocator_checker #(
   parameter int unsigned NUM_FRAMES  = 65536,
   parameter int unsigned FRAME_SHIFT = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // [51:0] start_addr, [103:52] end_addr
   input  logic [bfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  logic [bfa_pkg::REQ_W-1:0]          req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [27:0] frame_addr, [31:28] zero
   input  logic [bfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] found
   input  logic                               rsp_tuser,
   output int unsigned                        outstanding,
   output int unsigned                        errors
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bfa_pkg::ADDR_W-1:0] frame_addr;
      logic                       found;
   } grant_type;

   bit [NUM_FRAMES-1:0] frame_used;
   logic [63:0]         freed_mark;
   grant_type           grants_q [$];

   initial begin
      outstanding = 0;
      errors = 0;
   end

   task automatic report_error(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic grant_type serve_request(logic [bfa_pkg::REQ_W-1:0] kind,
                                               logic [63:0] start_addr,
                                               logic [63:0] end_addr);
      grant_type   grant;
      logic [63:0] first;
      logic [63:0] last;
      logic [63:0] f;
      logic [63:0] addr;
      grant = '0;
      first = start_addr >> FRAME_SHIFT;
      case (kind)
         bfa_pkg::REQ_ALLOC: begin
            for (f = 0; f <= freed_mark; f++) begin
               if (!frame_used[f]) begin
                  frame_used[f] = 1'b1;
                  addr = f << FRAME_SHIFT;
                  grant.frame_addr = addr[bfa_pkg::ADDR_W-1:0];
                  grant.found = 1'b1;
                  break;
               end
            end
         end
         bfa_pkg::REQ_FREE: begin
            if (first < NUM_FRAMES)
               frame_used[first] = 1'b0;
         end
         bfa_pkg::REQ_RESERVE: begin
            last = (end_addr + (64'd1 << FRAME_SHIFT) - 64'd1) >> FRAME_SHIFT;
            if (last > NUM_FRAMES)
               last = NUM_FRAMES;
            for (f = first; f < last; f++)
               frame_used[f] = 1'b1;
         end
         default: begin
            last = end_addr >> FRAME_SHIFT;
            if (last > NUM_FRAMES)
               last = NUM_FRAMES;
            if (first < last) begin
               for (f = first; f < last; f++)
                  frame_used[f] = 1'b0;
               if (last - 64'd1 > freed_mark)
                  freed_mark = last - 64'd1;
            end
         end
      endcase
      return grant;
   endfunction

   always @(posedge clock) begin
      grant_type                       want;
      logic [bfa_pkg::RSP_DATA_W-1:0]  want_data;
      if (reset) begin
         frame_used = '1;
         freed_mark = '0;
         grants_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_q.size() == 0) begin
               report_error($sformatf("response with nothing pending: frame_addr %h found %b",
                                      rsp_tdata, rsp_tuser));
            end else begin
               want = grants_q.pop_front();
               want_data = '0;
               want_data[bfa_pkg::ADDR_W-1:0] = want.frame_addr;
               if (rsp_tdata !== want_data)
                  report_error($sformatf("frame_addr got %h want %h", rsp_tdata, want_data));
               if (rsp_tuser !== want.found)
                  report_error($sformatf("found got %b want %b", rsp_tuser, want.found));
            end
         end
         if (req_tvalid && req_tready)
            grants_q.push_back(serve_request(req_tuser, req_tdata[51:0], req_tdata[103:52]));
      end
      outstanding <= grants_q.size();
   end

endmodule

// ===== bench/bitmap_frame_allocator_test.sv =====
// Testbench top for the bitmap frame allocator: request stimulus, response back-pressure, verdict.
module bitmap_frame_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     NUM_FRAMES    = 65536;
   localparam int unsigned     FRAME_SHIFT   = 12;
   localparam int unsigned     WORD_BITS     = 64;
   localparam int unsigned     REGION_FRAMES = 512;
   localparam int unsigned     RANDOM_ITEMS  = 800;
   localparam int unsigned     HOLD_CYCLES   = 400;
   localparam longint unsigned CYCLE_LIMIT   = 8_000_000;
   localparam logic [bfa_pkg::ADDR_IN_W-1:0] ADDR_MAX = '1;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bfa_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [bfa_pkg::REQ_W-1:0]      req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bfa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   int unsigned                    outstanding;
   int unsigned                    errors;
   bit                             steady = 1'b0;
   bit                             hold_off_due = 1'b0;
   longint unsigned                cycles = 0;

   bitmap_frame_allocator #(
      .NUM_FRAMES (NUM_FRAMES),
      .FRAME_SHIFT(FRAME_SHIFT),
      .WORD_BITS  (WORD_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   bitmap_frame_allocator_checker #(
      .NUM_FRAMES (NUM_FRAMES),
      .FRAME_SHIFT(FRAME_SHIFT)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .outstanding(outstanding),
      .errors     (errors)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // response side: sparse random stalls, one long hold-off on request
   initial begin
      int unsigned held;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 6);
            @(posedge clock);
         end
      end
   end

   function automatic logic [bfa_pkg::ADDR_IN_W-1:0] any_addr();
      logic [63:0] a;
      a = {$urandom, $urandom};
      return a[bfa_pkg::ADDR_IN_W-1:0];
   endfunction

   function automatic logic [bfa_pkg::ADDR_IN_W-1:0] addr_in(int unsigned frame);
      logic [bfa_pkg::ADDR_IN_W-1:0] a;
      a = frame;
      return (a << FRAME_SHIFT) | $urandom_range((1 << FRAME_SHIFT) - 1);
   endfunction

   task automatic send_request(logic [bfa_pkg::REQ_W-1:0] kind,
                               logic [bfa_pkg::ADDR_IN_W-1:0] start_addr,
                               logic [bfa_pkg::ADDR_IN_W-1:0] end_addr);
      if (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {end_addr, start_addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      int unsigned               n;
      int unsigned               roll;
      int unsigned               first;
      int unsigned               span;
      logic [bfa_pkg::REQ_W-1:0] kind;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(bfa_pkg::REQ_ALLOC, '0, '0);               // nothing free after reset
      send_request(bfa_pkg::REQ_FREE, '0, ADDR_MAX);
      send_request(bfa_pkg::REQ_ALLOC, ADDR_MAX, '0);         // frame zero, found set
      send_request(bfa_pkg::REQ_FREE, ADDR_MAX, ADDR_MAX);    // past the bitmap: ignored
      send_request(bfa_pkg::REQ_FREE, addr_in(NUM_FRAMES - 1), '0);
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);               // mark still zero
      send_request(bfa_pkg::REQ_RESERVE, 52'h5000, 52'h5000); // empty range
      send_request(bfa_pkg::REQ_RELEASE, 52'h9000, 52'h8fff); // start past end
      send_request(bfa_pkg::REQ_RELEASE, 52'h1234, 52'h4fff); // end rounds down
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);
      send_request(bfa_pkg::REQ_RESERVE, 52'h2000, 52'h2001); // end rounds up
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);
      send_request(bfa_pkg::REQ_RESERVE, ADDR_MAX, ADDR_MAX);
      send_request(bfa_pkg::REQ_RELEASE, '0, ADDR_MAX);       // clamped, mark to top
      send_request(bfa_pkg::REQ_RESERVE, '0, ADDR_MAX);
      send_request(bfa_pkg::REQ_ALLOC, ADDR_MAX, ADDR_MAX);   // full scan, none free
      send_request(bfa_pkg::REQ_FREE, addr_in(NUM_FRAMES - 1), ADDR_MAX);
      send_request(bfa_pkg::REQ_ALLOC, '0, ADDR_MAX);         // top frame
      send_request(bfa_pkg::REQ_RELEASE, addr_in(0), ADDR_MAX);
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);
      send_request(bfa_pkg::REQ_ALLOC, '0, '0);

      // random traffic kept mostly in the low frames so scans stay short
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 450);
         if (n == 100)
            hold_off_due = 1'b1;
         roll  = $urandom_range(99);
         first = $urandom_range(REGION_FRAMES - 1);
         span  = $urandom_range(40);
         if (roll < 35) begin
            send_request(bfa_pkg::REQ_ALLOC, any_addr(), any_addr());
         end else if (roll < 60) begin
            if ($urandom_range(9) == 0)
               send_request(bfa_pkg::REQ_FREE, any_addr(), any_addr());
            else
               send_request(bfa_pkg::REQ_FREE, addr_in(first), any_addr());
         end else if (roll < 96) begin
            kind = (roll < 78) ? bfa_pkg::REQ_RESERVE : bfa_pkg::REQ_RELEASE;
            send_request(kind, addr_in(first), addr_in(first + span));
         end else begin
            kind = ($urandom_range(1) == 0) ? bfa_pkg::REQ_RESERVE : bfa_pkg::REQ_RELEASE;
            if (roll < 99)
               send_request(kind, any_addr(), any_addr());
            else
               send_request(kind, addr_in(first), any_addr());
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
